### sv/becsu_pkg.sv
// ----------------------------------------------------------------------------
// becsu_pkg: shared types and constants
// Command transaction format, kind codes and default sizes.
// ----------------------------------------------------------------------------
package becsu_pkg;

  localparam int NODES_DEF  = 256;
  localparam int GROUPS_DEF = 8;
  localparam int LAYERS_DEF = 4;

  localparam int NODE_W  = 8;
  localparam int GROUP_W = 3;
  localparam int LAYER_W = 2;
  localparam int VALUE_W = 16;
  localparam int KIND_W  = 2;

  localparam int QDEPTH = 2;

  typedef enum logic [KIND_W-1:0] {
    K_ADJ  = 2'd0,
    K_LBL  = 2'd1,
    K_CNT  = 2'd2,
    K_SWAP = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [NODE_W-1:0]    node_a;
    logic [NODE_W-1:0]    node_b;
    logic [GROUP_W-1:0]   group_a;
    logic [GROUP_W-1:0]   group_b;
    logic [LAYER_W-1:0]   layer;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### sv/becsu_front.sv
// ----------------------------------------------------------------------------
// becsu_front: command intake
// Checks index ranges and forwards valid transactions to the queue.
// ----------------------------------------------------------------------------
module becsu_front #(
  parameter int NODES  = becsu_pkg::NODES_DEF,
  parameter int GROUPS = becsu_pkg::GROUPS_DEF,
  parameter int LAYERS = becsu_pkg::LAYERS_DEF
) (
  input  logic                         accept,
  input  logic [becsu_pkg::KIND_W-1:0]  kind,
  input  logic [becsu_pkg::NODE_W-1:0]  node_a,
  input  logic [becsu_pkg::NODE_W-1:0]  node_b,
  input  logic [becsu_pkg::GROUP_W-1:0] group_a,
  input  logic [becsu_pkg::GROUP_W-1:0] group_b,
  input  logic [becsu_pkg::LAYER_W-1:0] layer,
  input  logic [becsu_pkg::VALUE_W-1:0] value,
  output logic                         push,
  output becsu_pkg::cmd_t              cmd
);

  logic na_ok, nb_ok, ga_ok, gb_ok, ly_ok, ok;

  assign na_ok = 32'(node_a) < NODES;
  assign nb_ok = 32'(node_b) < NODES;
  assign ga_ok = 32'(group_a) < GROUPS;
  assign gb_ok = 32'(group_b) < GROUPS;
  assign ly_ok = 32'(layer) < LAYERS;

  always_comb begin
    unique case (becsu_pkg::kind_t'(kind))
      becsu_pkg::K_ADJ:  ok = na_ok && nb_ok && ly_ok;
      becsu_pkg::K_LBL:  ok = na_ok && ga_ok;
      becsu_pkg::K_CNT:  ok = ga_ok && gb_ok && ly_ok;
      becsu_pkg::K_SWAP: ok = na_ok && nb_ok;
      default:           ok = 1'b0;
    endcase
  end

  // out-of-range transactions are dropped here
  assign push = accept && ok;

  always_comb begin
    cmd.kind    = becsu_pkg::kind_t'(kind);
    cmd.node_a  = node_a;
    cmd.node_b  = node_b;
    cmd.group_a = group_a;
    cmd.group_b = group_b;
    cmd.layer   = layer;
    cmd.value   = value;
  end

endmodule

### sv/becsu_fifo.sv
// ----------------------------------------------------------------------------
// becsu_fifo: command queue
// Short register queue between intake and the update engine.
// ----------------------------------------------------------------------------
module becsu_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  becsu_pkg::cmd_t  din,
  input  logic             pop,
  output becsu_pkg::cmd_t  dout,
  output becsu_pkg::qstat_t stat
);

  localparam int PW = (becsu_pkg::QDEPTH > 1) ? $clog2(becsu_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(becsu_pkg::QDEPTH + 1);

  becsu_pkg::cmd_t mem_r [becsu_pkg::QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign stat.full  = cnt_r == CW'(becsu_pkg::QDEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign dout = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(becsu_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(becsu_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

### sv/becsu_back.sv
// ----------------------------------------------------------------------------
// becsu_back: update engine
// Owns adjacency, label and count memories; runs loads, swaps and reports.
// ----------------------------------------------------------------------------
module becsu_back #(
  parameter int NODES  = becsu_pkg::NODES_DEF,
  parameter int GROUPS = becsu_pkg::GROUPS_DEF,
  parameter int LAYERS = becsu_pkg::LAYERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  becsu_pkg::cmd_t               cmd,
  input  becsu_pkg::qstat_t             qstat,
  output logic                          pop,
  output logic                          clearing,
  output logic                          out_strobe,
  output logic [becsu_pkg::GROUP_W-1:0] out_group_row,
  output logic [becsu_pkg::GROUP_W-1:0] out_group_col,
  output logic [becsu_pkg::LAYER_W-1:0] out_layer_out,
  output logic [becsu_pkg::VALUE_W-1:0] out_edge_count,
  output logic                          out_last
);

  localparam int NW = $clog2(NODES);
  localparam int GW = $clog2(GROUPS);
  localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int AW = $clog2(NODES * NODES);
  localparam int CW = $clog2(LAYERS * GROUPS * GROUPS);
  localparam int VW = becsu_pkg::VALUE_W;

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_LA    = 14'b00000000000100,
    S_LB    = 14'b00000000001000,
    S_LC    = 14'b00000000010000,
    S_NODE  = 14'b00000000100000,
    S_NODED = 14'b00000001000000,
    S_LAYER = 14'b00000010000000,
    S_CRD   = 14'b00000100000000,
    S_CWR   = 14'b00001000000000,
    S_CWM   = 14'b00010000000000,
    S_SWL   = 14'b00100000000000,
    S_SWL2  = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [LAYERS-1:0] adj_mem [NODES*NODES];
  logic [GW-1:0]     lbl_mem [NODES];
  logic [VW-1:0]     cnt_mem [LAYERS*GROUPS*GROUPS];

  logic [LAYERS-1:0] adj_qa, adj_qb;
  logic [GW-1:0]     lbl_q;
  logic [VW-1:0]     cnt_q;

  logic [AW-1:0] clr_r, clr_nxt;
  logic [NW-1:0] na_r, na_nxt, nb_r, nb_nxt, i_r, i_nxt;
  logic [GW-1:0] g1_r, g1_nxt, g2_r, g2_nxt, gi_r, gi_nxt, c_r, c_nxt;
  logic [LW-1:0] l_r, l_nxt;
  logic [LAYERS-1:0] ba_r, ba_nxt, diff_r, diff_nxt;
  logic ph_r, ph_nxt, sec_r, sec_nxt;
  logic [VW-1:0] v_r, v_nxt, v_calc;

  logic em_v_r, em_v_nxt, em_last_r, em_last_nxt;
  logic [GW-1:0] em_row_r, em_row_nxt, em_col_r, em_col_nxt;
  logic [LW-1:0] em_l_r, em_l_nxt;

  logic          adj_we, lbl_we, cnt_we;
  logic [AW-1:0] adj_wa, adj_ra, adj_rb;
  logic [LW-1:0] adj_wl;
  logic [NW-1:0] lbl_wa, lbl_ra;
  logic [GW-1:0] lbl_wd;
  logic [CW-1:0] cnt_wa, cnt_ra;
  logic [VW-1:0] cnt_wd;
  logic [GW-1:0] op_row, em_row;
  logic          dec;

  function automatic logic [AW-1:0] adj_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
    adj_addr = AW'(r) * AW'(NODES) + AW'(c);
  endfunction

  function automatic logic [CW-1:0] cnt_addr(input logic [LW-1:0] l, input logic [GW-1:0] r,
                                             input logic [GW-1:0] c);
    cnt_addr = CW'(l) * CW'(GROUPS * GROUPS) + CW'(r) * CW'(GROUPS) + CW'(c);
  endfunction

  assign clearing = state_r == S_CLR;
  assign pop      = (state_r == S_IDLE) && !qstat.empty;
  assign op_row   = ph_r ? g2_r : g1_r;
  assign em_row   = sec_r ? g2_r : g1_r;
  // row g1 moves opposite to row g2
  assign dec      = ba_r[l_r] ^ ph_r;

  always_comb begin
    if (dec) begin
      v_calc = (cnt_q == '0) ? cnt_q : cnt_q - 1'b1;
    end else begin
      v_calc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    end
  end

  assign adj_ra = adj_addr(i_r, na_r);
  assign adj_rb = adj_addr(i_r, nb_r);

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    na_nxt      = na_r;
    nb_nxt      = nb_r;
    i_nxt       = i_r;
    g1_nxt      = g1_r;
    g2_nxt      = g2_r;
    gi_nxt      = gi_r;
    c_nxt       = c_r;
    l_nxt       = l_r;
    ba_nxt      = ba_r;
    diff_nxt    = diff_r;
    ph_nxt      = ph_r;
    sec_nxt     = sec_r;
    v_nxt       = v_r;
    em_v_nxt    = 1'b0;
    em_last_nxt = 1'b0;
    em_row_nxt  = em_row_r;
    em_col_nxt  = em_col_r;
    em_l_nxt    = em_l_r;
    adj_we      = 1'b0;
    adj_wa      = adj_addr(NW'(cmd.node_a), NW'(cmd.node_b));
    adj_wl      = LW'(cmd.layer);
    lbl_we      = 1'b0;
    lbl_wa      = NW'(cmd.node_a);
    lbl_wd      = GW'(cmd.group_a);
    lbl_ra      = i_r;
    cnt_we      = 1'b0;
    cnt_wa      = cnt_addr(LW'(cmd.layer), GW'(cmd.group_a), GW'(cmd.group_b));
    cnt_wd      = cmd.value;
    cnt_ra      = cnt_addr(l_r, op_row, gi_r);

    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(NODES * NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!qstat.empty) begin
          unique case (cmd.kind)
            becsu_pkg::K_ADJ: adj_we = 1'b1;
            becsu_pkg::K_LBL: lbl_we = 1'b1;
            becsu_pkg::K_CNT: cnt_we = 1'b1;
            becsu_pkg::K_SWAP: begin
              na_nxt    = NW'(cmd.node_a);
              nb_nxt    = NW'(cmd.node_b);
              state_nxt = S_LA;
            end
            default: ;
          endcase
        end
      end
      S_LA: begin
        lbl_ra    = na_r;
        state_nxt = S_LB;
      end
      S_LB: begin
        lbl_ra    = nb_r;
        g1_nxt    = lbl_q;
        state_nxt = S_LC;
      end
      S_LC: begin
        g2_nxt = lbl_q;
        i_nxt  = '0;
        state_nxt = (lbl_q == g1_r) ? S_SWL : S_NODE;
      end
      S_NODE: begin
        if (i_r == na_r || i_r == nb_r) begin
          if (i_r == NW'(NODES - 1)) begin
            state_nxt = S_SWL;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          state_nxt = S_NODED;
        end
      end
      S_NODED: begin
        ba_nxt    = adj_qa;
        diff_nxt  = adj_qa ^ adj_qb;
        gi_nxt    = lbl_q;
        l_nxt     = '0;
        ph_nxt    = 1'b0;
        state_nxt = S_LAYER;
      end
      S_LAYER, S_CWM: begin
        if (state_r == S_CWM) begin
          cnt_we = 1'b1;
          cnt_wa = cnt_addr(l_r, gi_r, op_row);
          cnt_wd = v_r;
        end
        if (state_r == S_LAYER && diff_r[l_r]) begin
          state_nxt = S_CRD;
        end else if (state_r == S_CWM && !ph_r) begin
          ph_nxt    = 1'b1;
          state_nxt = S_CRD;
        end else begin
          ph_nxt = 1'b0;
          if (l_r == LW'(LAYERS - 1)) begin
            if (i_r == NW'(NODES - 1)) begin
              state_nxt = S_SWL;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = S_NODE;
            end
          end else begin
            l_nxt     = l_r + 1'b1;
            state_nxt = S_LAYER;
          end
        end
      end
      S_CRD: begin
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cnt_we    = 1'b1;
        cnt_wa    = cnt_addr(l_r, op_row, gi_r);
        cnt_wd    = v_calc;
        v_nxt     = v_calc;
        state_nxt = S_CWM;
      end
      S_SWL: begin
        lbl_we    = 1'b1;
        lbl_wa    = na_r;
        lbl_wd    = g2_r;
        state_nxt = S_SWL2;
      end
      S_SWL2: begin
        lbl_we    = 1'b1;
        lbl_wa    = nb_r;
        lbl_wd    = g1_r;
        l_nxt     = '0;
        c_nxt     = '0;
        sec_nxt   = 1'b0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cnt_ra     = cnt_addr(l_r, em_row, c_r);
        em_v_nxt   = 1'b1;
        em_row_nxt = em_row;
        em_col_nxt = c_r;
        em_l_nxt   = l_r;
        if (c_r == GW'(GROUPS - 1)) begin
          c_nxt = '0;
          if (l_r == LW'(LAYERS - 1)) begin
            l_nxt = '0;
            if (!sec_r && g1_r != g2_r) begin
              sec_nxt = 1'b1;
            end else begin
              em_last_nxt = 1'b1;
              state_nxt   = S_IDLE;
            end
          end else begin
            l_nxt = l_r + 1'b1;
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      em_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      em_v_r  <= em_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    na_r      <= na_nxt;
    nb_r      <= nb_nxt;
    i_r       <= i_nxt;
    g1_r      <= g1_nxt;
    g2_r      <= g2_nxt;
    gi_r      <= gi_nxt;
    c_r       <= c_nxt;
    l_r       <= l_nxt;
    ba_r      <= ba_nxt;
    diff_r    <= diff_nxt;
    ph_r      <= ph_nxt;
    sec_r     <= sec_nxt;
    v_r       <= v_nxt;
    em_last_r <= em_last_nxt;
    em_row_r  <= em_row_nxt;
    em_col_r  <= em_col_nxt;
    em_l_r    <= em_l_nxt;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      adj_mem[clr_r] <= '0;
    end else if (adj_we) begin
      adj_mem[adj_wa][adj_wl] <= cmd.value[0];
    end
    adj_qa <= adj_mem[adj_ra];
    adj_qb <= adj_mem[adj_rb];
  end

  always_ff @(posedge clk) begin
    if (lbl_we) begin
      lbl_mem[lbl_wa] <= lbl_wd;
    end
    lbl_q <= lbl_mem[lbl_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_q <= cnt_mem[cnt_ra];
  end

  assign out_strobe     = em_v_r;
  assign out_group_row  = becsu_pkg::GROUP_W'(em_row_r);
  assign out_group_col  = becsu_pkg::GROUP_W'(em_col_r);
  assign out_layer_out  = becsu_pkg::LAYER_W'(em_l_r);
  assign out_edge_count = cnt_q;
  assign out_last       = em_v_r && em_last_r;

endmodule

### sv/block_edge_count_swap_update.sv
// ----------------------------------------------------------------------------
// block_edge_count_swap_update: swap-driven group edge count update
// Intake and range check, command queue, and the memory-based update engine.
// ----------------------------------------------------------------------------
// Load transactions are written by the engine from idle; accepted transactions are
// registered in the queue before the engine takes them. The time a swap takes is
// set by the node scan over the adjacency memory and the count read-modify-write;
// the scan is skipped when both nodes share a group. Results follow one per cycle.
// After reset the adjacency memory is cleared, with busy high. Results cannot stall.
module block_edge_count_swap_update #(
  parameter int NODES  = becsu_pkg::NODES_DEF,
  parameter int GROUPS = becsu_pkg::GROUPS_DEF,
  parameter int LAYERS = becsu_pkg::LAYERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [becsu_pkg::KIND_W-1:0]  in_kind,
  input  logic [becsu_pkg::NODE_W-1:0]  in_node_a,
  input  logic [becsu_pkg::NODE_W-1:0]  in_node_b,
  input  logic [becsu_pkg::GROUP_W-1:0] in_group_a,
  input  logic [becsu_pkg::GROUP_W-1:0] in_group_b,
  input  logic [becsu_pkg::LAYER_W-1:0] in_layer,
  input  logic [becsu_pkg::VALUE_W-1:0] in_value,
  output logic                          out_strobe,
  output logic [becsu_pkg::GROUP_W-1:0] out_group_row,
  output logic [becsu_pkg::GROUP_W-1:0] out_group_col,
  output logic [becsu_pkg::LAYER_W-1:0] out_layer_out,
  output logic [becsu_pkg::VALUE_W-1:0] out_edge_count,
  output logic                          out_last
);

  logic              push, pop, clearing, accept;
  becsu_pkg::cmd_t   push_cmd, head_cmd;
  becsu_pkg::qstat_t qstat;

  assign busy   = qstat.full || clearing;
  assign accept = start && !busy;

  becsu_front #(.NODES(NODES), .GROUPS(GROUPS), .LAYERS(LAYERS)) u_front (
    .accept  (accept),
    .kind    (in_kind),
    .node_a  (in_node_a),
    .node_b  (in_node_b),
    .group_a (in_group_a),
    .group_b (in_group_b),
    .layer   (in_layer),
    .value   (in_value),
    .push    (push),
    .cmd     (push_cmd)
  );

  becsu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_cmd),
    .pop   (pop),
    .dout  (head_cmd),
    .stat  (qstat)
  );

  becsu_back #(.NODES(NODES), .GROUPS(GROUPS), .LAYERS(LAYERS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (head_cmd),
    .qstat          (qstat),
    .pop            (pop),
    .clearing       (clearing),
    .out_strobe     (out_strobe),
    .out_group_row  (out_group_row),
    .out_group_col  (out_group_col),
    .out_layer_out  (out_layer_out),
    .out_edge_count (out_edge_count),
    .out_last       (out_last)
  );

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_strobe)
    else $error("result during adjacency clear");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !push)
    else $error("queue overflow");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_strobe)
    else $error("result after last of swap");

endmodule
